// ===== hw/rtl/fd_pkg.sv =====
// Shared constants, codes and controller/datapath types of the frame rate decimator.
package fd_pkg;

  localparam int HISTORY_DEPTH = 32;
  localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
  localparam int VALID_W       = $clog2(HISTORY_DEPTH + 1);
  localparam int TIME_W        = 48;
  localparam int FPS_W         = 10;
  localparam int CREDIT_W      = 11;
  localparam int DIV_W         = 50;
  localparam int SMALL_W       = 11;
  localparam int DIV_CNT_W     = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET     = 3'd0,
    CFG_WINDOW     = 3'd1,
    CFG_RESET_GAP  = 3'd2,
    CFG_CORR_INTVL = 3'd3,
    CFG_MIN_DIV    = 3'd4,
    CFG_OVER_DIV   = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_UPDATE,
    ACT_SCAN,
    ACT_SPAN,
    ACT_EST_VALID,
    ACT_EST_SET,
    ACT_OVER,
    ACT_ABOVE_CLR,
    ACT_BRANCH_B,
    ACT_BELOW_INC,
    ACT_CRED,
    ACT_ABOVE_FIN,
    ACT_OUT
  } act_e;

  typedef enum logic [2:0] {
    DIV_MINF,
    DIV_EST,
    DIV_STEP,
    DIV_CRED,
    DIV_ABOVE
  } div_op_e;

  typedef struct packed {
    act_e    act;
    logic    div_start;
    div_op_e div_op;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic scan_stop;
    logic est_needed;
    logic rate_above;
    logic branch_a;
    logic above_nz;
    logic below_ge_step;
    logic above_lt_q;
    logic div_busy;
  } sts_t;

  function automatic logic [TIME_W-1:0] abs_diff(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== hw/rtl/fd_if.sv =====
// Valid/ready channel interfaces for arrival items and decision items.
interface fd_in_if;
  logic                          valid;
  logic                          ready;
  logic [fd_pkg::TIME_W-1:0]     arrival_ms;

  modport source (output valid, output arrival_ms, input ready);
  modport sink (input valid, input arrival_ms, output ready);
endinterface

interface fd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          drop;
  logic [fd_pkg::FPS_W-1:0]      estimated_fps;

  modport source (output valid, output drop, output estimated_fps, input ready);
  modport sink (input valid, input drop, input estimated_fps, output ready);
endinterface

// ===== hw/rtl/fd_div.sv =====
// Restoring divider, one quotient bit per cycle.
module fd_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fd_pkg::DIV_CNT_W-1:0] count_i,
  input  logic [fd_pkg::DIV_W-1:0]     dividend_i,
  input  logic [fd_pkg::DIV_W-1:0]     divisor_i,
  output logic                         busy_o,
  output logic [fd_pkg::DIV_W-1:0]     quo_o,
  output logic [fd_pkg::DIV_W-1:0]     rem_o
);

  logic [fd_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [fd_pkg::DIV_W-1:0]     dvd_q, dvd_d, dvs_q, dvs_d, quo_q, quo_d, rem_q, rem_d;
  logic [fd_pkg::DIV_W-1:0]     trial;

  assign trial = {rem_q[fd_pkg::DIV_W-2:0], dvd_q[fd_pkg::DIV_W-1]};

  always_comb begin
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    dvs_d = dvs_q;
    quo_d = quo_q;
    rem_d = rem_q;
    if (start_i) begin
      cnt_d = count_i;
      dvd_d = dividend_i;
      dvs_d = divisor_i;
      quo_d = '0;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      dvd_d = {dvd_q[fd_pkg::DIV_W-2:0], 1'b0};
      if (trial >= dvs_q) begin
        rem_d = trial - dvs_q;
        quo_d = {quo_q[fd_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[fd_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/fd_dp.sv =====
// Datapath: configuration, arrival history, rate estimate and drop bookkeeping.
module fd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [fd_pkg::TIME_W-1:0]     arrival_ms_i,
  input  fd_pkg::cmd_t                  cmd_i,
  output fd_pkg::sts_t                  sts_o,
  output logic                          drop_o,
  output logic [fd_pkg::FPS_W-1:0]      est_fps_o
);

  localparam int TW = fd_pkg::TIME_W;
  localparam int DW = fd_pkg::DIV_W;
  localparam int SW = fd_pkg::SMALL_W;

  // configuration
  logic [7:0]  target_q, corr_intvl_q, min_div_q, over_div_q;
  logic [15:0] window_q, reset_gap_q;

  // persistent state
  logic [TW-1:0]               hist_q [fd_pkg::HISTORY_DEPTH];
  logic [TW-1:0]               last_q;
  logic [1:0]                  ch_q;
  logic [7:0]                  ccnt_q;
  logic [fd_pkg::CREDIT_W-1:0] credit_q;
  logic [9:0]                  below_q, above_q;

  // per-item working registers
  logic [TW-1:0]                 t_q, gap_q, lastv_q, span_q;
  logic                          first_q, clr_q, zero_q, drop_q;
  logic [11:0]                   k_q;
  logic [fd_pkg::HIST_IDX_W-1:0] idx_q;
  logic [fd_pkg::VALID_W-1:0]    valid_q;
  logic [fd_pkg::FPS_W-1:0]      est_q;
  logic [SW-1:0]                 over_q;
  logic                          out_drop_q;
  logic [fd_pkg::FPS_W-1:0]      out_est_q;

  // divider
  logic                         div_busy;
  logic [DW-1:0]                div_quo, div_rem, dvd, dvs;
  logic [fd_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [TW-1:0] h_cur;
  logic [TW:0]   age;
  logic          stop_entry;
  logic [25:0]   corr_prod;
  logic          slow_frame;
  logic [11:0]   over_s;
  logic [7:0]    min_div_eff, over_div_eff;
  logic [DW-1:0] ch_term;

  assign h_cur      = hist_q[idx_q];
  assign age        = {1'b0, t_q} - {1'b0, h_cur};
  assign stop_entry = (h_cur == '0) || (!age[TW] && (age[TW-1:0] > TW'(window_q)));
  assign corr_prod  = 26'(k_q) * 26'(gap_q[13:0]);
  assign slow_frame = (gap_q[TW-1:14] != '0) || (corr_prod >= 26'd10000);
  assign over_s     = 12'($signed({credit_q[fd_pkg::CREDIT_W-1], credit_q})
                      + $signed({2'b00, est_q}) - $signed({4'b0000, target_q}));
  assign min_div_eff  = (min_div_q == '0) ? 8'd1 : min_div_q;
  assign over_div_eff = (over_div_q == '0) ? 8'd1 : over_div_q;
  assign ch_term      = ch_q[1] ? DW'({span_q, 1'b0}) : (ch_q[0] ? DW'(span_q) : '0);

  // operand select for the shared divider
  always_comb begin
    dvd     = '0;
    dvs     = DW'(1);
    div_cnt = fd_pkg::DIV_CNT_W'(SW);
    case (cmd_i.div_op)
      fd_pkg::DIV_MINF: begin
        dvd = {SW'(target_q), {(DW-SW){1'b0}}};
        dvs = DW'(min_div_eff);
      end
      fd_pkg::DIV_EST: begin
        dvd     = DW'(17'(valid_q) * 17'd2000) + ch_term;
        dvs     = DW'({span_q, 1'b0});
        div_cnt = fd_pkg::DIV_CNT_W'(DW);
      end
      fd_pkg::DIV_STEP: begin
        dvd = {SW'(est_q), {(DW-SW){1'b0}}};
        dvs = DW'(over_q);
      end
      fd_pkg::DIV_CRED: begin
        dvd = {div_rem[SW-1:0], {(DW-SW){1'b0}}};
        dvs = DW'(over_div_eff);
      end
      fd_pkg::DIV_ABOVE: begin
        dvd = {over_q, {(DW-SW){1'b0}}};
        dvs = DW'(target_q);
      end
      default: begin
        dvd = '0;
      end
    endcase
  end

  fd_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .count_i   (div_cnt),
    .dividend_i(dvd),
    .divisor_i (dvs),
    .busy_o    (div_busy),
    .quo_o     (div_quo),
    .rem_o     (div_rem)
  );

  assign sts_o.zero          = zero_q;
  assign sts_o.scan_stop     = stop_entry || (idx_q == fd_pkg::HIST_IDX_W'(fd_pkg::HISTORY_DEPTH - 1));
  assign sts_o.est_needed    = (8'(valid_q) > div_quo[7:0]) && (valid_q > fd_pkg::VALID_W'(2))
                               && (span_q != '0);
  assign sts_o.rate_above    = est_q > 10'(target_q);
  assign sts_o.branch_a      = (over_q != '0) && ({over_q, 1'b0} < 12'(est_q));
  assign sts_o.above_nz      = above_q != '0;
  assign sts_o.below_ge_step = {1'b0, below_q} >= div_quo[SW-1:0];
  assign sts_o.above_lt_q    = {1'b0, above_q} < div_quo[SW-1:0];
  assign sts_o.div_busy      = div_busy;

  // configuration and state that persists between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= 8'd30;
      window_q     <= 16'd1000;
      reset_gap_q  <= 16'd3000;
      corr_intvl_q <= 8'd3;
      min_div_q    <= 8'd2;
      over_div_q   <= 8'd2;
      for (int i = 0; i < fd_pkg::HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
      last_q   <= '0;
      ch_q     <= '0;
      ccnt_q   <= '0;
      credit_q <= '0;
      below_q  <= '0;
      above_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          fd_pkg::CFG_TARGET:     target_q     <= cfg_data_i[7:0];
          fd_pkg::CFG_WINDOW:     window_q     <= cfg_data_i;
          fd_pkg::CFG_RESET_GAP:  reset_gap_q  <= cfg_data_i;
          fd_pkg::CFG_CORR_INTVL: corr_intvl_q <= cfg_data_i[7:0];
          fd_pkg::CFG_MIN_DIV:    min_div_q    <= cfg_data_i[7:0];
          fd_pkg::CFG_OVER_DIV:   over_div_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      case (cmd_i.act)
        fd_pkg::ACT_UPDATE: begin
          last_q <= t_q;
          if (!first_q) begin
            for (int i = fd_pkg::HISTORY_DEPTH - 1; i > 0; i--) begin
              hist_q[i] <= clr_q ? '0 : hist_q[i-1];
            end
            if (gap_q != '0) begin
              if (slow_frame) begin
                ch_q <= 2'd1;
              end else if (ccnt_q >= corr_intvl_q) begin
                ch_q   <= 2'd2;
                ccnt_q <= '0;
              end else begin
                ch_q   <= 2'd0;
                ccnt_q <= ccnt_q + 1'b1;
              end
            end
          end
          hist_q[0] <= t_q;
        end
        fd_pkg::ACT_OVER: begin
          if (sts_o.rate_above && over_s[11]) begin
            credit_q <= '0;
          end
        end
        fd_pkg::ACT_ABOVE_CLR: above_q <= '0;
        fd_pkg::ACT_BRANCH_B:  below_q <= '0;
        fd_pkg::ACT_BELOW_INC: below_q <= below_q + 1'b1;
        fd_pkg::ACT_CRED: begin
          credit_q <= fd_pkg::CREDIT_W'(0) - div_quo[SW-1:0];
          below_q  <= 10'd1;
        end
        fd_pkg::ACT_ABOVE_FIN: begin
          if (sts_o.above_lt_q) begin
            above_q <= above_q + 1'b1;
          end else begin
            credit_q <= div_rem[SW-1:0];
            above_q  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.act)
      fd_pkg::ACT_LOAD: begin
        t_q     <= arrival_ms_i;
        gap_q   <= fd_pkg::abs_diff(arrival_ms_i, last_q);
        first_q <= (last_q == '0);
        clr_q   <= fd_pkg::abs_diff(arrival_ms_i, hist_q[0]) > TW'(reset_gap_q);
        k_q     <= {1'b0, target_q, 3'b000} + {3'b000, target_q, 1'b0} + 12'(target_q);
        zero_q  <= (target_q == '0);
        drop_q  <= (target_q == '0);
        est_q   <= '0;
      end
      fd_pkg::ACT_UPDATE: begin
        idx_q   <= '0;
        valid_q <= '0;
      end
      fd_pkg::ACT_SCAN: begin
        if (!stop_entry) begin
          valid_q <= valid_q + 1'b1;
          lastv_q <= h_cur;
        end
        idx_q <= idx_q + 1'b1;
      end
      fd_pkg::ACT_SPAN:      span_q <= fd_pkg::abs_diff(t_q, lastv_q);
      fd_pkg::ACT_EST_VALID: est_q  <= fd_pkg::FPS_W'(valid_q);
      fd_pkg::ACT_EST_SET: begin
        est_q <= (div_quo[DW-1:fd_pkg::FPS_W] != '0) ? '1 : div_quo[fd_pkg::FPS_W-1:0];
      end
      fd_pkg::ACT_OVER:      over_q <= over_s[11] ? '0 : over_s[SW-1:0];
      fd_pkg::ACT_ABOVE_CLR: drop_q <= 1'b1;
      fd_pkg::ACT_CRED:      drop_q <= 1'b1;
      fd_pkg::ACT_ABOVE_FIN: drop_q <= sts_o.above_lt_q;
      fd_pkg::ACT_OUT: begin
        out_drop_q <= drop_q;
        out_est_q  <= est_q;
      end
      default: ;
    endcase
  end

  assign drop_o    = out_drop_q;
  assign est_fps_o = out_est_q;

endmodule

// ===== hw/rtl/fd_ctrl.sv =====
// Controller: sequences load, history scan, divisions and result hand-off.
module fd_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  fd_pkg::sts_t sts_i,
  output fd_pkg::cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_PREP    = 12'b0000_0000_0010,
    S_SCAN    = 12'b0000_0000_0100,
    S_W_MINF  = 12'b0000_0000_1000,
    S_ESTSEL  = 12'b0000_0001_0000,
    S_W_EST   = 12'b0000_0010_0000,
    S_RATE    = 12'b0000_0100_0000,
    S_DECIDE  = 12'b0000_1000_0000,
    S_W_STEP  = 12'b0001_0000_0000,
    S_W_CRED  = 12'b0010_0000_0000,
    S_W_ABOVE = 12'b0100_0000_0000,
    S_DONE    = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_comb begin
    state_d          = state_q;
    cmd_o.act        = fd_pkg::ACT_NONE;
    cmd_o.div_start  = 1'b0;
    cmd_o.div_op     = fd_pkg::DIV_MINF;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.act = fd_pkg::ACT_LOAD;
          state_d   = S_PREP;
        end
      end
      S_PREP: begin
        if (sts_i.zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.act = fd_pkg::ACT_UPDATE;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.act = fd_pkg::ACT_SCAN;
        if (sts_i.scan_stop) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = fd_pkg::DIV_MINF;
          state_d         = S_W_MINF;
        end
      end
      S_W_MINF: begin
        cmd_o.act = fd_pkg::ACT_SPAN;
        if (!sts_i.div_busy) begin
          state_d = S_ESTSEL;
        end
      end
      S_ESTSEL: begin
        cmd_o.act = fd_pkg::ACT_EST_VALID;
        if (sts_i.est_needed) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = fd_pkg::DIV_EST;
          state_d         = S_W_EST;
        end else begin
          state_d = S_RATE;
        end
      end
      S_W_EST: begin
        if (!sts_i.div_busy) begin
          cmd_o.act = fd_pkg::ACT_EST_SET;
          state_d   = S_RATE;
        end
      end
      S_RATE: begin
        cmd_o.act = fd_pkg::ACT_OVER;
        state_d   = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts_i.rate_above) begin
          state_d = S_DONE;
        end else if (sts_i.branch_a) begin
          if (sts_i.above_nz) begin
            cmd_o.act = fd_pkg::ACT_ABOVE_CLR;
            state_d   = S_DONE;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_op    = fd_pkg::DIV_STEP;
            state_d         = S_W_STEP;
          end
        end else begin
          cmd_o.act       = fd_pkg::ACT_BRANCH_B;
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = fd_pkg::DIV_ABOVE;
          state_d         = S_W_ABOVE;
        end
      end
      S_W_STEP: begin
        if (!sts_i.div_busy) begin
          if (sts_i.below_ge_step) begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_op    = fd_pkg::DIV_CRED;
            state_d         = S_W_CRED;
          end else begin
            cmd_o.act = fd_pkg::ACT_BELOW_INC;
            state_d   = S_DONE;
          end
        end
      end
      S_W_CRED: begin
        if (!sts_i.div_busy) begin
          cmd_o.act = fd_pkg::ACT_CRED;
          state_d   = S_DONE;
        end
      end
      S_W_ABOVE: begin
        if (!sts_i.div_busy) begin
          cmd_o.act = fd_pkg::ACT_ABOVE_FIN;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.act = fd_pkg::ACT_OUT;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (cmd_o.act == fd_pkg::ACT_OUT) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;

endmodule

// ===== hw/rtl/frame_rate_decimator.sv =====
// Top level of the frame rate decimator: controller, datapath and channel hookup.
//
// Usage: each item on in_i carries one frame arrival time in ms (nonzero,
// nondecreasing). For every item exactly one item leaves on out_o: drop (1 drop
// the frame, 0 pass it) and estimated_fps, the truncated incoming rate.
// Six registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle:
// target fps, rate window, history reset gap, correction interval, min-frames
// divisor and overshoot divisor. A target of zero drops every frame.
// One item at a time. An item scans the history one entry per cycle, then
// runs a shared one-bit-per-cycle divider: the min-frames division, the rate
// estimate when it is needed, and up to two more divisions of the drop
// decision. A zero target skips the scan and the divisions. The next item is
// taken once the result is in the output register.
// Reset clears the history, the last arrival, all counters and the credit, and
// loads the register defaults (30, 1000, 3000, 3, 2, 2).
// Receiver stall: the result holds in the output register; the block finishes
// the following item and then holds it until the output register frees.
module frame_rate_decimator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fd_in_if.sink                         in_i,
  fd_out_if.source                      out_o,
  input  logic                          cfg_we_i,
  input  logic [fd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  fd_pkg::cmd_t cmd;
  fd_pkg::sts_t sts;

  // sequence the item through the datapath
  fd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hold configuration, history and drop counters; drive the result payload
  fd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .arrival_ms_i(in_i.arrival_ms),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .drop_o      (out_o.drop),
    .est_fps_o   (out_o.estimated_fps)
  );

endmodule

// ===== hw/rtl/fd_checker.sv =====
// Port-level checks of the frame rate decimator and their bind.
module fd_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic                     out_drop_i,
  input logic [fd_pkg::FPS_W-1:0] out_est_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_drop_i) && $stable(out_est_i))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while one is in work");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared one cycle after its item");

endmodule

bind frame_rate_decimator fd_checker u_fd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_drop_i (out_o.drop),
  .out_est_i  (out_o.estimated_fps)
);

// ===== bench/tb_frame_rate_decimator.sv =====
// Self-checking bench for the frame rate decimator: predicted keep/drop decisions against the block.
module tb_frame_rate_decimator;
  timeunit 1ns;
  timeprecision 1ps;
  import fd_pkg::*;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int DRAIN_CYCLES    = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  fd_in_if  in_ch ();
  fd_out_if out_ch ();

  frame_rate_decimator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decision predictor state and its copy of the registers.
  logic [TIME_W-1:0] hist_q [HISTORY_DEPTH];
  logic [TIME_W-1:0] last_arrival_q;
  int unsigned corr_halves_q, corr_count_q, below_cnt_q, above_cnt_q;
  int credit_q;
  int unsigned reg_target, reg_window, reg_gap, reg_corr, reg_minf_div, reg_over_div;

  typedef struct {
    logic             drop;
    logic [FPS_W-1:0] fps;
  } decision_t;
  decision_t decision_q [$];

  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_dropped = 0;
  int idle_cycles = 0;
  logic [TIME_W-1:0] clock_ms;   // running arrival time for the generators
  bit long_hold = 1'b0;          // asks the receiver to hold off for a long stretch
  bit rx_stall_en = 1'b1;

  function automatic logic [TIME_W-1:0] tdist(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  task automatic reset_predictor();
    foreach (hist_q[i]) hist_q[i] = '0;
    last_arrival_q = '0;
    corr_halves_q = 0; corr_count_q = 0; below_cnt_q = 0; above_cnt_q = 0;
    credit_q = 0;
    reg_target = 30; reg_window = 1000; reg_gap = 3000;
    reg_corr = 3; reg_minf_div = 2; reg_over_div = 2;
  endtask

  // Uniform drop decision with overshoot credit; returns 1 to drop.
  function automatic bit spread_drop(int rate);
    int tgt, over, step, d;
    tgt = int'(reg_target);
    over = credit_q + (rate - tgt);
    if (over < 0) begin
      over = 0;
      credit_q = 0;
    end
    if (over != 0 && 2 * over < rate) begin
      if (above_cnt_q != 0) begin
        above_cnt_q = 0;
        return 1'b1;
      end
      step = rate / over;
      if (int'(below_cnt_q) >= step) begin
        d = (reg_over_div != 0) ? int'(reg_over_div) : 1;
        credit_q = -((rate % over) / d);
        below_cnt_q = 1;
        return 1'b1;
      end
      below_cnt_q = (below_cnt_q + 1) & 10'h3ff;
      return 1'b0;
    end
    below_cnt_q = 0;
    if (int'(above_cnt_q) < over / tgt) begin
      above_cnt_q = (above_cnt_q + 1) & 10'h3ff;
      return 1'b1;
    end
    credit_q = over % tgt;
    above_cnt_q = 0;
    return 1'b0;
  endfunction

  // Advance the predictor by one frame and return its decision.
  function automatic decision_t predict_decision(logic [TIME_W-1:0] t);
    decision_t r;
    bit first;
    logic [TIME_W-1:0] gap, span;
    longint unsigned est, minf, divv;
    int unsigned valid;
    bit stop;
    if (reg_target == 0) begin
      r.drop = 1'b1;
      r.fps = '0;
      return r;
    end
    first = (last_arrival_q == 0);
    gap = tdist(t, last_arrival_q);
    last_arrival_q = t;
    // shift or clear the history
    if (!first) begin
      if (tdist(t, hist_q[0]) > reg_gap) begin
        foreach (hist_q[i]) hist_q[i] = '0;
      end else begin
        for (int i = HISTORY_DEPTH - 2; i >= 0; i--) hist_q[i + 1] = hist_q[i];
      end
    end
    hist_q[0] = t;
    // correction from the instantaneous rate
    if (!first && gap != 0) begin
      if (64'(11) * reg_target * 64'(gap) >= 64'd10000) begin
        corr_halves_q = 1;
      end else if (corr_count_q >= reg_corr) begin
        corr_halves_q = 2;
        corr_count_q = 0;
      end else begin
        corr_halves_q = 0;
        corr_count_q = (corr_count_q + 1) & 8'hff;
      end
    end
    // count entries inside the window
    valid = 0;
    stop = 1'b0;
    for (int n = 0; n < HISTORY_DEPTH; n++) begin
      if (!stop) begin
        if (hist_q[n] == 0 || (t > hist_q[n] && t - hist_q[n] > reg_window)) stop = 1'b1;
        else valid++;
      end
    end
    divv = (reg_minf_div != 0) ? reg_minf_div : 1;
    minf = reg_target / divv;
    est = valid;
    if (valid > minf && valid > 2) begin
      span = tdist(t, hist_q[valid - 1]);
      if (span != 0)
        est = (64'd2000 * valid + 64'(corr_halves_q) * span) / (64'd2 * span);
    end
    if (est > 1023) est = 1023;
    r.fps = est[FPS_W-1:0];
    r.drop = 1'b0;
    if (est > reg_target) r.drop = spread_drop(int'(est));
    return r;
  endfunction

  // Write one register at a falling edge; only called while the block is idle.
  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TARGET:     reg_target   = val & 8'hff;
      CFG_WINDOW:     reg_window   = val & 16'hffff;
      CFG_RESET_GAP:  reg_gap      = val & 16'hffff;
      CFG_CORR_INTVL: reg_corr     = val & 8'hff;
      CFG_MIN_DIV:    reg_minf_div = val & 8'hff;
      CFG_OVER_DIV:   reg_over_div = val & 8'hff;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (decision_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic setup_regs(int unsigned tgt, int unsigned win, int unsigned gap,
                            int unsigned corr, int unsigned mdiv, int unsigned odiv);
    wait_drained();
    write_reg(CFG_TARGET, tgt);
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_RESET_GAP, gap);
    write_reg(CFG_CORR_INTVL, corr);
    write_reg(CFG_MIN_DIV, mdiv);
    write_reg(CFG_OVER_DIV, odiv);
  endtask

  // Offer one frame and hold it until accepted; predict on acceptance.
  task automatic send_frame(logic [TIME_W-1:0] t);
    in_ch.valid <= 1'b1;
    in_ch.arrival_ms <= t;
    do @(posedge clk_i); while (!in_ch.ready);
    decision_q.push_back(predict_decision(t));
    n_sent++;
    @(negedge clk_i);
  endtask

  // Lower valid only when the sender actually pauses.
  task automatic sender_gap(int unsigned cycles);
    if (cycles != 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  // Advance the running clock by a gap and send; bursts with random pauses.
  task automatic send_stream(int unsigned count, int unsigned max_gap_ms);
    int unsigned burst;
    burst = $urandom_range(1, 12);
    repeat (count) begin
      clock_ms = clock_ms + $urandom_range(0, max_gap_ms);
      if (clock_ms == 0) clock_ms = 1;
      send_frame(clock_ms);
      if (--burst == 0) begin
        burst = $urandom_range(1, 12);
        sender_gap($urandom_range(1, 40));
      end
    end
    sender_gap(1);
  endtask

  // Receiver: stall pattern of its own, plus a long hold when asked.
  initial begin
    int unsigned phase;
    out_ch.ready = 1'b0;
    phase = 0;
    forever begin
      @(negedge clk_i);
      phase++;
      if (long_hold) out_ch.ready <= 1'b0;
      else if (!rx_stall_en) out_ch.ready <= 1'b1;
      else out_ch.ready <= ((phase % 7) < 4) ? 1'b1 : ($urandom_range(0, 3) == 0);
    end
  end

  // Check every accepted decision against the oldest prediction.
  always @(posedge clk_i) begin
    decision_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (decision_q.size() == 0) begin
        $error("unexpected decision item: drop=%0b fps=%0d", out_ch.drop, out_ch.estimated_fps);
        errors++;
      end else begin
        want = decision_q.pop_front();
        if (out_ch.drop !== want.drop) begin
          $error("drop: expected %0b, actual %0b", want.drop, out_ch.drop);
          errors++;
        end
        if (out_ch.estimated_fps !== want.fps) begin
          $error("estimated_fps: expected %0d, actual %0d", want.fps, out_ch.estimated_fps);
          errors++;
        end
        n_checked++;
        if (want.drop) n_dropped++;
      end
    end
  end

  // Watchdog: count cycles in which nothing moves on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_CYCLES) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Extremes of the arrival field, zero target, first frame, equal and backwards times.
  task automatic test_directed();
    setup_regs(30, 1000, 3000, 3, 2, 2);
    send_frame(48'h0000_0000_0001);
    send_frame(48'h0000_0000_0001);                  // zero gap
    send_frame(48'h0000_0000_0011);
    send_frame(48'h0000_0000_0005);                  // time going backwards
    send_frame(48'hffff_ffff_ffff);                  // huge jump clears history
    send_frame(48'hffff_ffff_ffff);
    send_frame(48'h0000_0000_0000);                  // zero stored, next is first frame
    send_frame(48'h5555_5555_5555);
    send_frame(48'haaaa_aaaa_aaaa);
    send_frame(48'h0000_0000_0000);
    sender_gap(1);
    setup_regs(0, 1000, 3000, 3, 2, 2);              // zero target drops every frame
    send_frame(48'h0000_0000_0100);
    send_frame(48'h0000_0000_0200);
    sender_gap(1);
    setup_regs(240, 65535, 65535, 0, 0, 0);          // divisors of zero act as one
    clock_ms = 48'h0000_0010_0000;
    repeat (8) begin
      clock_ms += 1;
      send_frame(clock_ms);
    end
    sender_gap(1);
    setup_regs(255, 1, 1, 255, 255, 255);            // target above the normal range
    repeat (5) begin
      clock_ms += $urandom_range(0, 2);
      send_frame(clock_ms);
    end
    sender_gap(1);
  endtask

  // Regular streams at a spread of rates and register settings.
  task automatic test_random_rates();
    repeat (14) begin
      setup_regs($urandom_range(1, 240), $urandom_range(200, 3000),
                 $urandom_range(50, 5000), $urandom_range(0, 8),
                 $urandom_range(1, 8), $urandom_range(1, 8));
      send_stream($urandom_range(60, 110), $urandom_range(1, 80));
    end
    // extremes of window and gap
    setup_regs(60, 65535, 65535, 255, 1, 255);
    send_stream(100, 20);
    setup_regs(1, 1, 1, 0, 255, 1);
    send_stream(60, 3);
  endtask

  // Random noise: wide jumps, backwards steps and random full-width values.
  task automatic test_noise();
    logic [TIME_W-1:0] t;
    setup_regs($urandom_range(0, 255), $urandom_range(1, 65535), $urandom_range(1, 65535),
               $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    repeat (120) begin
      case ($urandom_range(0, 3))
        0: t = {$urandom(), $urandom()};
        1: t = clock_ms - $urandom_range(0, 50);
        default: t = clock_ms + $urandom_range(0, 5000);
      endcase
      clock_ms = t;
      send_frame(t);
    end
    sender_gap(1);
  endtask

  // Receiver holds off long while the sender keeps offering; then sender waits out the drain.
  task automatic test_backpressure();
    setup_regs(30, 1000, 3000, 3, 2, 2);
    fork
      begin
        long_hold = 1'b1;
        repeat (800) @(negedge clk_i);
        long_hold = 1'b0;
      end
      send_stream(40, 10);
    join
    wait_drained();
    rx_stall_en = 1'b0;                              // stretch with no receiver stalls
    send_stream(60, 15);
    rx_stall_en = 1'b1;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.arrival_ms = '0;
    reset_predictor();
    clock_ms = 48'd1000;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_rates();
    test_noise();
    test_backpressure();
    wait_drained();
    $display("Covered %0d frames (%0d dropped) over directed, rate, noise and stall phases.",
             n_checked, n_dropped);
    if (errors == 0 && decision_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/fd_pkg.sv
hw/rtl/fd_if.sv
hw/rtl/fd_div.sv
hw/rtl/fd_dp.sv
hw/rtl/fd_ctrl.sv
hw/rtl/frame_rate_decimator.sv
hw/rtl/fd_checker.sv
bench/tb_frame_rate_decimator.sv
